// ===== rtl/lpks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpks_pkg;

   localparam int TABLE_SIZE_DEF = 64;
   localparam int NUM_BANKS_DEF  = 4;
   localparam int KEY_W          = 16;
   localparam int SLOT_W         = 6;

   // operation codes; code 3 is treated as a lookup
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_MISSING = 2'd2;

   typedef struct packed {
      logic [1:0]       func;
      logic [1:0]       bank;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/lpks_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// slot table: one write port, one read port, registered read data
module lpks_mem #(
   parameter int DEPTH = lpks_pkg::TABLE_SIZE_DEF * lpks_pkg::NUM_BANKS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire lpks_pkg::entry_type       wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output      lpks_pkg::entry_type       rd_data
);
   import lpks_pkg::*;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/lpks_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

// key mod TABLE_SIZE by reciprocal multiplication: quotient estimate,
// back-multiply and subtract, then one compare and subtract
module lpks_hash #(
   parameter int TABLE_SIZE = lpks_pkg::TABLE_SIZE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [lpks_pkg::KEY_W-1:0]     key,
   output      logic                           done,
   output      logic [$clog2(TABLE_SIZE)-1:0]  home
);
   import lpks_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int REM_W  = IDX_W + 1;
   localparam int PROD_W = 2 * KEY_W;
   // floor(2^KEY_W / TABLE_SIZE); the quotient estimate is short by at most one
   localparam logic [KEY_W-1:0]  RECIP_C = KEY_W'((1 << KEY_W) / TABLE_SIZE);
   localparam logic [PROD_W-1:0] TS_P    = PROD_W'(TABLE_SIZE);
   localparam logic [REM_W-1:0]  TS_C    = REM_W'(TABLE_SIZE);

   logic              mul_vld_ff, mul_vld_in;
   logic              sub_vld_ff, sub_vld_in;
   logic              done_ff, done_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  home_ff, home_in;
   logic [PROD_W-1:0] back_prod;
   logic [PROD_W-1:0] diff;
   logic [REM_W-1:0]  rem_fix;

   always_comb begin
      mul_vld_in = start;
      sub_vld_in = mul_vld_ff;
      done_in    = sub_vld_ff;
      key_in     = key_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      home_in    = home_ff;
      // remainder estimate lies in [0, 2*TABLE_SIZE)
      back_prod  = PROD_W'(prod_ff[PROD_W-1:KEY_W]) * TS_P;
      diff       = PROD_W'(key_ff) - back_prod;
      rem_fix    = (rem_ff >= TS_C) ? rem_ff - TS_C : rem_ff;
      if (start) begin
         key_in  = key;
         prod_in = PROD_W'(key) * PROD_W'(RECIP_C);
      end
      if (mul_vld_ff) begin
         rem_in = diff[REM_W-1:0];
      end
      if (sub_vld_ff) begin
         home_in = rem_fix[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         sub_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         mul_vld_ff <= mul_vld_in;
         sub_vld_ff <= sub_vld_in;
         done_ff    <= done_in;
      end
      key_ff  <= key_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      home_ff <= home_in;
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

`default_nettype wire

// ===== rtl/linear_probe_key_set.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Flow: a req accepted in ST_IDLE waits in ST_HASH for the key reduction; ST_PROBE then
//   checks one slot per cycle through the single read port of the slot table, and
//   ST_DONE loads the rsp register; a new req is taken only once the last is done, and
//   a word left waiting on rsp_ready holds the next result in ST_DONE.
// Reset: synchronous; afterwards a clearing pass over all NUM_BANKS*TABLE_SIZE entries
//   (256 at defaults) zeroes every valid mark; req_ready stays low meanwhile.
module linear_probe_key_set #(
   parameter int TABLE_SIZE = lpks_pkg::TABLE_SIZE_DEF,
   parameter int NUM_BANKS  = lpks_pkg::NUM_BANKS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire lpks_pkg::req_type req,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      lpks_pkg::rsp_type rsp
);
   import lpks_pkg::*;

   localparam int DEPTH  = TABLE_SIZE * NUM_BANKS;
   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [ADDR_W-1:0] base_ff, base_in;        // bank * TABLE_SIZE
   logic [IDX_W-1:0]  probe_slot_ff, probe_slot_in;  // slot being read
   logic [IDX_W-1:0]  chk_slot_ff, chk_slot_in;      // slot whose data is back
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;        // probe distance of chk slot
   logic              chk_vld_ff, chk_vld_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [1:0]        bank_mod;
   logic              hash_start;
   logic              hash_done;
   logic [IDX_W-1:0]  hash_home;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_data;

   logic              is_insert;
   logic              is_remove;
   logic              entry_free;
   logic              entry_match;
   logic              probe_last;

   // bank wraps modulo NUM_BANKS; a 2-bit bank needs at most one subtract
   always_comb begin
      if (NUM_BANKS == 1) begin
         bank_mod = 2'd0;
      end else if (32'(req.bank) >= NUM_BANKS) begin
         bank_mod = req.bank - 2'(NUM_BANKS);
      end else begin
         bank_mod = req.bank;
      end
   end

   assign is_insert   = (req_ff.func == FUNC_INSERT);
   assign is_remove   = (req_ff.func == FUNC_REMOVE);
   assign entry_free  = !rd_data.valid;
   assign entry_match = rd_data.valid && (rd_data.key == req_ff.key);
   assign probe_last  = (chk_idx_ff == LAST_SLOT);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      base_in       = base_ff;
      probe_slot_in = probe_slot_ff;
      chk_slot_in   = chk_slot_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      clr_in        = clr_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      hash_start    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = ADDR_W'(chk_slot_ff) + base_ff;
      wr_data       = '{valid: 1'b1, key: req_ff.key};
      rd_addr       = ADDR_W'(probe_slot_ff) + base_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in     = req;
               base_in    = ADDR_W'(32'(bank_mod) * TABLE_SIZE);
               hash_start = 1'b1;
               state_in   = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               probe_slot_in = hash_home;
               chk_idx_in    = '0;
               chk_vld_in    = 1'b0;
               state_in      = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // read the next slot every cycle, wrapping within the bank; reads after the deciding slot are dropped
            probe_slot_in = (probe_slot_ff == LAST_SLOT) ? '0 : probe_slot_ff + 1'b1;
            chk_slot_in   = probe_slot_ff;
            chk_vld_in    = 1'b1;
            if (chk_vld_ff) begin
               chk_idx_in = chk_idx_ff + 1'b1;
               if (is_insert) begin
                  if (entry_free) begin
                     wr_en    = 1'b1;
                     res_in   = '{status: STATUS_OK, slot: SLOT_W'(chk_slot_ff)};
                     state_in = ST_DONE;
                  end else if (probe_last) begin
                     res_in   = '{status: STATUS_FULL, slot: '0};
                     state_in = ST_DONE;
                  end
               end else begin
                  if (entry_free) begin
                     res_in   = '{status: STATUS_MISSING, slot: '0};
                     state_in = ST_DONE;
                  end else if (entry_match) begin
                     wr_en    = is_remove;
                     wr_data  = '{valid: 1'b0, key: req_ff.key};
                     res_in   = '{status: STATUS_OK, slot: SLOT_W'(chk_slot_ff)};
                     state_in = ST_DONE;
                  end else if (probe_last) begin
                     res_in   = '{status: STATUS_MISSING, slot: '0};
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      base_ff       <= base_in;
      probe_slot_ff <= probe_slot_in;
      chk_slot_ff   <= chk_slot_in;
      chk_idx_ff    <= chk_idx_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   lpks_hash #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .start(hash_start),
      .key  (req.key),
      .done (hash_done),
      .home (hash_home)
   );

   // the only write lands as the item finishes; the next item reads
   // no sooner than the key reduction allows, so no forwarding is needed
   lpks_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule

`default_nettype wire

// ===== rtl/lpks_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpks_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire lpks_pkg::rsp_type rsp
);
   import lpks_pkg::*;

   // one word in flight: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted on consecutive cycles");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != STATUS_OK) |-> rsp.slot == '0)
      else $error("slot nonzero on failed operation");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status == STATUS_OK) || (rsp.status == STATUS_FULL) ||
                    (rsp.status == STATUS_MISSING))
      else $error("bad status code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_ready)
      else $error("outputs active right after reset");

endmodule

bind linear_probe_key_set lpks_checker u_lpks_checker (.*);

`default_nettype wire
